// ===== rtl/gtr_pkg.sv =====
package gtr_pkg;

    // Screen and character cell geometry
    localparam logic [8:0] SCREEN_WIDTH = 9'd240;
    localparam logic [7:0] CELL_W       = 8'd6;
    localparam logic [2:0] COL_LAST     = 3'd5;   // spacing column, always background
    localparam logic [2:0] ROW_LAST     = 3'd7;
    localparam logic [2:0] GLYPH_COL_TOP = 3'd4;

    // Printable code range and the substitute glyph
    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd127;
    localparam logic [7:0] SUBST_CODE = 8'h3F;    // question mark

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Five column bytes, column 0 in the top byte, bit 0 of a byte is the top row
    typedef logic [39:0] glyph_t;

    typedef struct packed {
        logic [7:0]  x;
        logic [7:0]  y;
        glyph_t      glyph;
        logic [15:0] fg;
        logic [15:0] bg;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic glyph_t glyph_rom(input logic [6:0] idx);
        glyph_t g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h7249494946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201590906;
            7'd32: g = 40'h3E415D594E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E41415173;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h0804081008;
            7'd95: g = 40'h7F4141417F;
            default: g = 40'h0201590906;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/gtr_queue.sv =====
module gtr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gtr_pkg::job_t       push_job,
    input  logic                pop,
    output gtr_pkg::job_t       head_job,
    output gtr_pkg::queue_stat_t stat
);

    gtr_pkg::job_t                mem_reg [gtr_pkg::QUEUE_DEPTH];
    logic [gtr_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [gtr_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [gtr_pkg::QCNT_W-1:0]   count_reg, count_next;

    localparam logic [gtr_pkg::QPTR_W-1:0] PTR_LAST = gtr_pkg::QPTR_W'(gtr_pkg::QUEUE_DEPTH - 1);
    localparam logic [gtr_pkg::QCNT_W-1:0] CNT_FULL = gtr_pkg::QCNT_W'(gtr_pkg::QUEUE_DEPTH);

    assign stat.full  = (count_reg == CNT_FULL);
    assign stat.empty = (count_reg == '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full))
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// ===== rtl/gtr_front.sv =====
module gtr_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  gtr_pkg::queue_stat_t q_stat,
    output logic                 push,
    output gtr_pkg::job_t        push_job
);

    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] row_reg, row_next;
    logic [7:0] cur_x, cur_y, code, sel_code;
    logic [8:0] cell_end;
    logic       accept, draw;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign code     = s_tdata[23:16];

    always_comb
    begin
        cur_x = s_tuser[0] ? s_tdata[7:0]  : cursor_reg;
        cur_y = s_tuser[0] ? s_tdata[15:8] : row_reg;
        // drop the character once the cell would touch the right edge
        cell_end = {1'b0, cur_x} + {1'b0, gtr_pkg::CELL_W};
        draw     = (cell_end < gtr_pkg::SCREEN_WIDTH);
        sel_code = (code inside {[gtr_pkg::FIRST_CODE:gtr_pkg::LAST_CODE]})
                   ? code : gtr_pkg::SUBST_CODE;

        push_job.x     = cur_x;
        push_job.y     = cur_y;
        push_job.glyph = gtr_pkg::glyph_rom(7'(sel_code - gtr_pkg::FIRST_CODE));
        push_job.fg    = s_tdata[39:24];
        push_job.bg    = s_tdata[55:40];
        push           = accept && draw;

        cursor_next = cursor_reg;
        row_next    = row_reg;
        if (accept)
        begin
            cursor_next = draw ? cell_end[7:0] : cur_x;
            row_next    = cur_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ===== rtl/gtr_back.sv =====
module gtr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtr_pkg::job_t        head_job,
    input  gtr_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast
);

    gtr_pkg::job_t job_reg, job_next, src;
    logic          active_reg, active_next;
    logic [2:0]    col_reg, col_next, col;
    logic [2:0]    row_reg, row_next, row;
    logic [2:0]    gcol;
    logic          tvalid_reg;
    logic [31:0]   tdata_reg, tdata_next;
    logic          tlast_reg, tlast_next;
    logic          free, have, emit, last, lit;

    assign free = !tvalid_reg || m_tready;
    assign have = active_reg || !q_stat.empty;
    assign emit = free && have;
    assign pop  = emit && !active_reg;

    always_comb
    begin
        src  = active_reg ? job_reg : head_job;
        col  = active_reg ? col_reg : '0;
        row  = active_reg ? row_reg : '0;
        last = (col == gtr_pkg::COL_LAST) && (row == gtr_pkg::ROW_LAST);
        gcol = gtr_pkg::GLYPH_COL_TOP - col;
        // spacing column is background; bottom row reads a zero bit from the font
        lit  = (col != gtr_pkg::COL_LAST) && src.glyph[{gcol, row}];

        tdata_next = {lit ? src.fg : src.bg, src.y + {5'd0, row}, src.x + {5'd0, col}};
        tlast_next = last;

        job_next    = job_reg;
        active_next = active_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (emit)
        begin
            job_next    = src;
            active_next = !last;
            if (col == gtr_pkg::COL_LAST)
            begin
                col_next = '0;
                row_next = row + 1'b1;
            end
            else
            begin
                col_next = col + 1'b1;
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tvalid_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            if (free)
            begin
                tvalid_reg <= have;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (emit)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= tlast_next;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !active_reg)
        else $error("job taken while a cell is still in progress");
    a_cell_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !last) |=> active_reg)
        else $error("cell ended before its last pixel");
    a_last_ends_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last) |=> (!active_reg && m_tvalid && m_tlast))
        else $error("last pixel did not close the cell");

endmodule

// ===== rtl/glyph_text_rasterizer_top.sv =====
// Text rasterizer: 5x7 font, one 6x8 cell per character.
// Slave channel takes one character word per handshake; first_of_line in
// s_tuser reloads the cursor and line row from start_x/start_y first.
// Master channel gives one pixel word per handshake, 48 per drawn character
// in row-major order, with m_tlast on the 48th.
// A character whose cell would reach the screen width is dropped and gives
// no pixels; the cursor then stays put.
// With an idle back end, the front writes an accepted character's job into
// the queue and the back then registers its pixel 0 in the output register.
// The back-end pixel sequencer emits one pixel per cycle while the receiver
// is ready; the front takes a dropped character without pushing a job. A
// two-job queue lets the front take the next character while the back is
// still drawing.
// Reset clears the cursor and row to zero, empties the queue and drops any
// pending pixel word.
// When the receiver stalls, hold the pixel word; the back stops, the queue
// fills and s_tready falls until room frees up.
module glyph_text_rasterizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // start_x[7:0], start_y[15:8], char_code[23:16],
                                   // fg_color[39:24], bg_color[55:40]
    input  logic [0:0]  s_tuser,   // first_of_line[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_color[31:16]
    output logic        m_tlast    // last_pixel
);

    gtr_pkg::job_t        push_job, head_job;
    gtr_pkg::queue_stat_t q_stat;
    logic                 push, pop;

    // classify characters, track cursor, fetch glyph
    gtr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // decouple the front from the pixel sequencer
    gtr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // walk the cell and drive the output register
    gtr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
